// File: rtl/core/sitda_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds widths, character codes and the queue item type; no dependencies.
package sitda_pkg;

	// Input integer width; bit VALUE_WIDTH-1 is the sign
	localparam int VALUE_WIDTH = 32;
	// Input bus width, rounded up to whole bytes
	localparam int IN_DATA_W   = ((VALUE_WIDTH + 7) / 8) * 8;

	// Output fields
	localparam int CHAR_W      = 8;
	localparam int LEN_W       = 4;
	localparam int OUT_DATA_W  = ((CHAR_W + LEN_W + 7) / 8) * 8;

	// Decimal digits needed for a VALUE_WIDTH-bit magnitude (log10(2) ~ 0.30103)
	localparam int DIGITS      = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int BCD_W       = 4 * DIGITS;
	localparam int DIG_IDX_W   = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	// Holds a run length of up to DIGITS + 1 characters
	localparam int TOTAL_W     = $clog2(DIGITS + 2);

	// Binary to BCD conversion: four magnitude bits per cycle
	localparam int BITS_PER_STEP = 4;
	localparam int STEPS       = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int PAD_W       = STEPS * BITS_PER_STEP;
	localparam int STEP_W      = (STEPS > 1) ? $clog2(STEPS) : 1;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Character codes
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

	// Classified item: sign and magnitude
	typedef struct packed {
		logic                   neg;
		logic [VALUE_WIDTH-1:0] mag;
	} item_t;

endpackage

// File: rtl/core/sitda_front.sv
// Front end: accepts integers and splits them into sign and magnitude.
// Depends on sitda_pkg.
module sitda_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [sitda_pkg::IN_DATA_W-1:0] s_tdata,  // [VALUE_WIDTH-1:0] value
	output logic                          push_valid,
	input  logic                          push_ready,
	output sitda_pkg::item_t              push_item
);
	import sitda_pkg::*;

	logic                   valid_q;
	item_t                  item_q;
	logic signed [VALUE_WIDTH-1:0] value;
	logic                   neg;

	assign value = s_tdata[VALUE_WIDTH-1:0];
	assign neg   = value[VALUE_WIDTH-1];

	// Take a new beat whenever the held item is gone or leaving
	assign s_tready   = !valid_q || push_ready;
	assign push_valid = valid_q;
	assign push_item  = item_q;

	// Hold valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	// Classify: magnitude of the most negative value fits unsigned in VALUE_WIDTH bits
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_q.neg <= neg;
			item_q.mag <= neg ? (~value[VALUE_WIDTH-1:0] + VALUE_WIDTH'(1))
			                  : value[VALUE_WIDTH-1:0];
		end
	end

endmodule

// File: rtl/core/sitda_queue.sv
// Short FIFO of classified items between front and back.
// Depends on sitda_pkg.
module sitda_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  sitda_pkg::item_t wr_item,
	output logic             rd_valid,
	input  logic             rd_ready,
	output sitda_pkg::item_t rd_item
);
	import sitda_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t              slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr;
	logic               do_rd;

	assign wr_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_item  = slot_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store written items
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	// Count never exceeds depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	// A read on an empty queue cannot happen
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> !do_rd)
		else $error("queue read while empty");

endmodule

// File: rtl/core/sitda_back.sv
// Back end: converts a magnitude to BCD by shift-and-add-3, four bits a cycle,
// sizes the run and emits one character per beat. Depends on sitda_pkg.
module sitda_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pop_valid,
	output logic                            pop_ready,
	input  sitda_pkg::item_t                pop_item,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [sitda_pkg::OUT_DATA_W-1:0] m_tdata,  // [7:0] character, [11:8] run_length
	output logic                            m_tlast
);
	import sitda_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIZE,
		ST_EMIT
	} state_t;

	state_t               state_q;
	logic                 neg_q;
	logic [PAD_W-1:0]     mag_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [STEP_W-1:0]    step_q;
	logic [DIG_IDX_W-1:0] dig_q;
	logic [TOTAL_W-1:0]   total_q;
	logic                 sign_pend_q;
	logic                 out_valid_q;
	logic [CHAR_W-1:0]    out_char_q;
	logic                 out_last_q;
	logic [LEN_W-1:0]     out_len_q;

	logic [PAD_W-1:0]     mag_nxt;
	logic [BCD_W-1:0]     bcd_nxt;
	logic [TOTAL_W-1:0]   ndig;
	logic                 slot_free;
	logic [3:0]           cur_digit;

	// One shift-and-add-3 step: correct digits of five or more, then shift in a bit
	function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd, input logic b);
		logic [BCD_W-1:0] fix;
		fix = bcd;
		for (int i = 0; i < DIGITS; i++) begin
			if (fix[4*i +: 4] >= 4'd5) begin
				fix[4*i +: 4] = fix[4*i +: 4] + 4'd3;
			end
		end
		return {fix[BCD_W-2:0], b};
	endfunction

	// Four conversion steps per cycle
	always_comb begin
		bcd_nxt = bcd_q;
		mag_nxt = mag_q;
		for (int b = 0; b < BITS_PER_STEP; b++) begin
			bcd_nxt = dabble(bcd_nxt, mag_nxt[PAD_W-1]);
			mag_nxt = {mag_nxt[PAD_W-2:0], 1'b0};
		end
	end

	// Count significant digits; zero still gives one
	always_comb begin
		ndig = TOTAL_W'(1);
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0) begin
				ndig = TOTAL_W'(i + 1);
			end
		end
	end

	assign pop_ready = (state_q == ST_IDLE);
	assign slot_free = !out_valid_q || m_tready;
	assign cur_digit = bcd_q[dig_q*4 +: 4];

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = OUT_DATA_W'({out_len_q, out_char_q});

	// Sequencer with its registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			out_last_q  <= 1'b0;
			out_len_q   <= '0;
			sign_pend_q <= 1'b0;
		end else begin
			// Load a beat when the slot frees up, drop it once taken
			if (state_q == ST_EMIT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (step_q == STEP_W'(STEPS - 1)) begin
						state_q <= ST_SIZE;
					end
				end
				ST_SIZE: begin
					sign_pend_q <= neg_q;
					state_q     <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_len_q   <= LEN_W'(total_q);
						if (sign_pend_q) begin
							out_char_q  <= CHAR_MINUS;
							out_last_q  <= 1'b0;
							sign_pend_q <= 1'b0;
						end else begin
							out_char_q <= CHAR_ZERO + CHAR_W'(cur_digit);
							out_last_q <= (dig_q == '0);
							if (dig_q == '0) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					neg_q  <= pop_item.neg;
					mag_q  <= PAD_W'(pop_item.mag);
					bcd_q  <= '0;
					step_q <= '0;
				end
			end
			ST_CONV: begin
				bcd_q  <= bcd_nxt;
				mag_q  <= mag_nxt;
				step_q <= step_q + 1'b1;
			end
			ST_SIZE: begin
				dig_q   <= DIG_IDX_W'(ndig - 1'b1);
				total_q <= ndig + TOTAL_W'(neg_q);
			end
			ST_EMIT: begin
				if (slot_free && !sign_pend_q && dig_q != '0) begin
					dig_q <= dig_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Emitted characters are a digit or the minus sign
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((out_char_q >= CHAR_ZERO && out_char_q <= CHAR_ZERO + 8'd9)
		              || out_char_q == CHAR_MINUS))
		else $error("illegal character emitted");

	// A minus sign is never the final character
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (out_char_q != CHAR_MINUS))
		else $error("run ends with minus sign");

	// A run of one character is never a minus sign
	a_single_is_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_len_q == LEN_W'(1)) |-> (out_char_q != CHAR_MINUS && m_tlast))
		else $error("single character run malformed");

	// Emission index stays inside the digit range
	a_dig_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (32'(dig_q) < DIGITS))
		else $error("digit index out of range");

endmodule

// File: rtl/core/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII converter. Each input beat carries one
// two's-complement integer; the block returns its decimal text as a run of
// output beats, most significant character first, with a leading '-' for
// negative values, a single '0' for zero and no leading zeros. The most
// negative value prints in full. Every beat carries the run length and the
// final beat has tlast set. A value goes through a load step in the
// converter, shift-and-add-3 at four bits a cycle, a sizing step and one
// emit step per character at the output register, which waits while the
// output stalls. A two-entry queue lets the front take new values while
// the converter is busy.
module signed_int_to_decimal_ascii (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [sitda_pkg::IN_DATA_W-1:0]  s_tdata,  // [31:0] value
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [sitda_pkg::OUT_DATA_W-1:0] m_tdata,  // [7:0] character, [11:8] run_length
	output logic                            m_tlast
);
	import sitda_pkg::*;

	logic  fq_valid;
	logic  fq_ready;
	item_t fq_item;
	logic  qb_valid;
	logic  qb_ready;
	item_t qb_item;

	// Classify incoming values
	sitda_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_item  (fq_item)
	);

	// Decouple front and back
	sitda_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_item  (fq_item),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready),
		.rd_item  (qb_item)
	);

	// Convert and emit characters
	sitda_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (qb_valid),
		.pop_ready (qb_ready),
		.pop_item  (qb_item),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
